>>> design/aesd_pkg.sv
// ----------------------------------------------------------------------------
// aesd_pkg: shared types, tables and GF(2^8) helpers for the AES decryptor
// S-box, inverse S-box, InvMixColumns and the per-stage control type.
// ----------------------------------------------------------------------------
`default_nettype none

package aesd_pkg;

    localparam int NUM_SLOTS = 15;   // round-key slots, one per pipeline stage

    // configuration register indexes
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_ROUND = 2'd1,
        KIND_FINAL = 2'd2
    } stage_kind_t;

    typedef struct packed {
        stage_kind_t kind;
        logic        bypass;
    } stage_ctrl_t;

    typedef struct packed {
        logic busy;
    } key_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // multiply by 9, 11, 13, 14 through the doubling chain
    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        for (int i = 0; i < 4; i++)
        begin
            a[i]   = w[31-8*i -: 8];
            a2[i]  = xtime(a[i]);
            a4[i]  = xtime(a2[i]);
            a8[i]  = xtime(a4[i]);
            m9[i]  = a8[i] ^ a[i];
            m11[i] = a8[i] ^ a2[i] ^ a[i];
            m13[i] = a8[i] ^ a4[i] ^ a[i];
            m14[i] = a8[i] ^ a4[i] ^ a2[i];
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // state byte b sits at [127-8b -: 8]; byte index = row + 4*column
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*c) -: 8] = INV_SBOX[s[127-8*(r+4*((c+4-r)%4)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix_state(input logic [127:0] s);
        return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
                inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
    endfunction

endpackage

`default_nettype wire

>>> design/aesd_key_expand.sv
// ----------------------------------------------------------------------------
// aesd_key_expand: sequential key schedule
// One schedule word per cycle; round keys land in per-stage slots, middle
// rounds passed through InvMixColumns.
// ----------------------------------------------------------------------------
`default_nettype none

module aesd_key_expand
    import aesd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [1:0]   mode,
    input  wire logic [255:0] key,
    output key_status_t       status,
    output logic [127:0]      round_keys [NUM_SLOTS]
);

    logic         busy_reg;
    logic [5:0]   idx_reg;
    logic [2:0]   cmod_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   rnd_reg;
    logic [1:0]   col_reg;
    logic [31:0]  win_reg [8];
    logic [127:0] rk_reg [NUM_SLOTS];

    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [31:0]  w_back;
    logic [31:0]  t;
    logic [31:0]  w_next;
    logic [31:0]  word_out;
    logic [3:0]   slot;
    logic [2:0]   cmod_next;
    logic         last_word;

    always_comb
    begin
        unique case (mode)
            MODE_128: begin nk = 4'd4; nr = 4'd10; w_back = win_reg[3]; end
            MODE_192: begin nk = 4'd6; nr = 4'd12; w_back = win_reg[5]; end
            default:  begin nk = 4'd8; nr = 4'd14; w_back = win_reg[7]; end
        endcase
    end

    always_comb
    begin
        t = win_reg[0];
        if (cmod_reg == 3'd0)
        begin
            t = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
        end
        else if (nk == 4'd8 && cmod_reg == 3'd4)
        begin
            t = sub_word(win_reg[0]);
        end
        if (idx_reg < {2'b00, nk})
        begin
            w_next = key[(3'd7 - idx_reg[2:0]) * 32 +: 32];
        end
        else
        begin
            w_next = w_back ^ t;
        end
        word_out  = (rnd_reg != 4'd0 && rnd_reg != nr) ? inv_mix_col(w_next) : w_next;
        slot      = (rnd_reg == 4'd0) ? 4'(NUM_SLOTS - 1) : nr - rnd_reg;
        cmod_next = ({1'b0, cmod_reg} == nk - 4'd1) ? 3'd0 : cmod_reg + 3'd1;
        last_word = (idx_reg == {nr, 2'b11});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            cmod_reg <= '0;
            rcon_reg <= 8'h01;
            rnd_reg  <= '0;
            col_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            cmod_reg <= '0;
            rcon_reg <= 8'h01;
            rnd_reg  <= '0;
            col_reg  <= '0;
        end
        else if (busy_reg)
        begin
            idx_reg  <= idx_reg + 6'd1;
            cmod_reg <= cmod_next;
            col_reg  <= col_reg + 2'd1;
            if (col_reg == 2'd3)
            begin
                rnd_reg <= rnd_reg + 4'd1;
            end
            if (cmod_reg == 3'd0 && idx_reg >= {2'b00, nk})
            begin
                rcon_reg <= xtime(rcon_reg);
            end
            if (last_word)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            win_reg[0] <= w_next;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            rk_reg[slot][(2'd3 - col_reg) * 32 +: 32] <= word_out;
        end
    end

    assign status.busy = busy_reg;
    assign round_keys  = rk_reg;

endmodule

`default_nettype wire

>>> design/aesd_round_stage.sv
// ----------------------------------------------------------------------------
// aesd_round_stage: one registered stage of the inverse cipher pipeline
// Add-key, full inverse round (or pass-through when bypassed) or final round, with its own valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module aesd_round_stage
    import aesd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire stage_ctrl_t  ctrl,
    input  wire logic [127:0] round_key,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [127:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [127:0]      out_data
);

    logic         valid_reg;
    logic [127:0] data_reg;
    logic [127:0] data_next;

    always_comb
    begin
        case (ctrl.kind)
            KIND_ADD:   data_next = in_data ^ round_key;
            KIND_ROUND: data_next = ctrl.bypass ? in_data
                                    : inv_mix_state(inv_sub_shift(in_data)) ^ round_key;
            KIND_FINAL: data_next = inv_sub_shift(in_data) ^ round_key;
            default:    data_next = in_data;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> design/aes_block_decryptor_top.sv
// ----------------------------------------------------------------------------
// aes_block_decryptor_top: AES-128/192/256 ECB decryptor, 15-stage pipeline
// Equivalent inverse cipher; the round keys of the key schedule sit in registers.
// ----------------------------------------------------------------------------
// Channel   | Role          | Payload
// s_axis    | block in      | tdata[63:0] cipher_hi, [127:64] cipher_lo
// m_axis    | block out     | tdata[63:0] plain_hi,  [127:64] plain_lo
// apb       | config        | 0x00 mode, 0x08..0x20 key parts 0..3
//
// Every block runs through all the stages for every key length; shorter keys
// pass through the unused round stages untouched. Throughput is one block per
// cycle while m_tready is high and no key schedule runs; each stage holds its
// own valid bit and stalls only when it is full and the stage after it cannot
// take its block, so bubbles are squeezed out. A key or mode write starts the
// key schedule, one word per cycle, during which s_tready is low. Reset clears
// config registers to 0; round keys are undefined until the first such write.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_decryptor_top
    import aesd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // stream in
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,    // [63:0] cipher_hi, [127:64] cipher_lo
    // stream out
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,    // [63:0] plain_hi, [127:64] plain_lo
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [1:0]   mode_reg;
    logic [63:0]  key_reg [4];
    logic         cfg_wr;
    logic [2:0]   reg_idx;
    logic         cfg_hit;
    logic [3:0]   nr;
    key_status_t  key_status;
    logic [127:0] round_keys [NUM_SLOTS];

    logic         valid_chain [NUM_SLOTS+1];
    logic         ready_chain [NUM_SLOTS+1];
    logic [127:0] data_chain  [NUM_SLOTS+1];

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (reg_idx <= REG_KEY3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_MODE: mode_reg   <= pwdata[1:0];
                REG_KEY0: key_reg[0] <= pwdata;
                REG_KEY1: key_reg[1] <= pwdata;
                REG_KEY2: key_reg[2] <= pwdata;
                REG_KEY3: key_reg[3] <= pwdata;
                default:  ;  // no register here
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE: prdata = {62'h0, mode_reg};
            REG_KEY0: prdata = key_reg[0];
            REG_KEY1: prdata = key_reg[1];
            REG_KEY2: prdata = key_reg[2];
            REG_KEY3: prdata = key_reg[3];
            default:  prdata = '0;
        endcase
    end

    aesd_key_expand u_key
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cfg_hit),
        .mode       (mode_reg),
        .key        ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .status     (key_status),
        .round_keys (round_keys)
    );

    // mode 3 runs as AES-256
    always_comb
    begin
        unique case (mode_reg)
            MODE_128: nr = 4'd10;
            MODE_192: nr = 4'd12;
            default:  nr = 4'd14;
        endcase
    end

    // stage 0 adds the last round key, stages 1..13 are inverse rounds
    // (idle above nr-1), stage 14 is the final round with key 0
    assign valid_chain[0] = s_tvalid && !key_status.busy;
    assign s_tready       = ready_chain[0] && !key_status.busy;
    assign data_chain[0]  = {s_tdata[63:0], s_tdata[127:64]};

    for (genvar p = 0; p < NUM_SLOTS; p++)
    begin : g_stage
        stage_ctrl_t ctrl;
        assign ctrl.kind   = (p == 0) ? KIND_ADD
                           : (p == NUM_SLOTS - 1) ? KIND_FINAL : KIND_ROUND;
        assign ctrl.bypass = (4'(p) >= nr);

        aesd_round_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .round_key (round_keys[p]),
            .in_valid  (valid_chain[p]),
            .in_ready  (ready_chain[p]),
            .in_data   (data_chain[p]),
            .out_valid (valid_chain[p+1]),
            .out_ready (ready_chain[p+1]),
            .out_data  (data_chain[p+1])
        );
    end

    assign m_tvalid                = valid_chain[NUM_SLOTS];
    assign ready_chain[NUM_SLOTS]  = m_tready;
    assign m_tdata = {data_chain[NUM_SLOTS][63:0], data_chain[NUM_SLOTS][127:64]};

`ifndef ASSERT_OFF
    // a mode or key register write always starts a fresh key schedule
    a_cfg_starts_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> key_status.busy)
        else $error("key schedule did not start after register write");

    // no block enters while round keys are being rewritten
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_status.busy |-> !s_tready)
        else $error("input accepted during key schedule");

    // a write to an unmapped address leaves the schedule alone
    a_bad_addr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && !cfg_hit && !key_status.busy) |=> !key_status.busy)
        else $error("unmapped write restarted key schedule");
`endif

endmodule

`default_nettype wire
